### rtl/efh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efh_pkg
// Shared constants, types and helpers of the explicit free-list heap allocator.
// ----------------------------------------------------------------------------
package efh_pkg;

  localparam int unsigned HEAP_BYTES = 32768;
  localparam int unsigned HEAP_WORDS = HEAP_BYTES / 8;
  localparam int unsigned WIDX_W     = $clog2(HEAP_WORDS);
  localparam int unsigned STEP_W     = $clog2(HEAP_WORDS) + 1;
  localparam int unsigned DW         = 32;

  typedef logic [DW-1:0]     dw_t;
  typedef logic [WIDX_W-1:0] widx_t;

  localparam dw_t HEAP_LIMIT  = dw_t'(HEAP_BYTES);
  localparam dw_t WSIZE       = dw_t'(8);
  localparam dw_t MIN_BLOCK   = dw_t'(32);
  localparam dw_t LOW2        = dw_t'(3);
  localparam dw_t LOW3        = dw_t'(7);
  localparam dw_t START_MARK  = dw_t'(8 | 3);
  localparam dw_t END_MARK    = dw_t'(3);
  localparam logic [15:0] CHUNK_RESET = 16'(1 << 10);

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;

  typedef struct packed {
    dw_t  a;
    dw_t  b;
    logic sub;
  } alu_op_t;

  typedef struct packed {
    dw_t  y;
    logic ge;
  } alu_res_t;

  typedef struct packed {
    logic  we;
    widx_t widx;
    dw_t   wdata;
    widx_t ridx;
  } mem_req_t;

  function automatic widx_t word_idx(dw_t a);
    return a[WIDX_W+2:3];
  endfunction

endpackage

### rtl/efh_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efh_alu
// Shared adder and unsigned comparator used by the steps of the sequencer.
// ----------------------------------------------------------------------------
module efh_alu (
  input  efh_pkg::alu_op_t  op_i,
  output efh_pkg::alu_res_t res_o
);

  logic [efh_pkg::DW:0] sum;

  always_comb begin
    if (op_i.sub) begin
      sum = {1'b0, op_i.a} - {1'b0, op_i.b};
    end else begin
      sum = {1'b0, op_i.a} + {1'b0, op_i.b};
    end
    res_o.y  = sum[efh_pkg::DW-1:0];
    res_o.ge = op_i.sub & ~sum[efh_pkg::DW];
  end

endmodule

### rtl/efh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efh_ram
// Heap word memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module efh_ram (
  input  logic               clk_i,
  input  efh_pkg::mem_req_t  req_i,
  output efh_pkg::dw_t       rdata_o
);

  efh_pkg::dw_t mem [efh_pkg::HEAP_WORDS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.widx] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.ridx];
  end

endmodule

### rtl/efh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efh_ctrl
// Command sequencer: init, first-fit allocate with split, free with coalesce.
// ----------------------------------------------------------------------------
module efh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         cmd_i,
  input  logic [15:0]        request_bytes_i,
  input  logic [14:0]        block_addr_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [14:0]        result_addr_o,
  output logic [1:0]         status_o,
  output efh_pkg::alu_op_t   alu_op_o,
  input  efh_pkg::alu_res_t  alu_res_i,
  output efh_pkg::mem_req_t  mem_req_o,
  input  efh_pkg::dw_t       rdata_i
);

  typedef enum logic [6:0] {
    S_IDLE, S_DONE,
    S_I0, S_I1, S_I2,
    S_G0, S_G1, S_G2, S_G3, S_G4,
    S_U0, S_U1, S_U2,
    S_N0, S_N1, S_N2, S_N3, S_N4,
    S_R0, S_R1, S_R2, S_R3, S_R4,
    S_A0, S_A1, S_W0, S_W1, S_W2, S_W3, S_AG,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_PR,
    S_P8, S_P9, S_P10, S_P11, S_P12,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8, S_F9,
    S_F11, S_F12, S_F13, S_F14,
    S_J0, S_J1, S_J2, S_J3, S_J4, S_J5, S_J6
  } state_e;

  state_e state_q, state_d, ret_q, ret_d, gret_q, gret_d, jret_q, jret_d;
  logic [15:0] cfg_q, cfg_d, req_q, req_d, brk_q, brk_d;
  efh_pkg::dw_t head_q, head_d, bp_q, bp_d, pv_q, pv_d, nd_q, nd_d;
  efh_pkg::dw_t nx_q, nx_d, lp_q, lp_d, asz_q, asz_d, sz_q, sz_d;
  efh_pkg::dw_t rest_q, rest_d, tmp_q, tmp_d, hdr_q, hdr_d, wa_q, wa_d;
  logic [efh_pkg::STEP_W-1:0] steps_q, steps_d;
  logic gfail_q, gfail_d;
  logic [14:0] res_q, res_d;
  logic [1:0] status_q, status_d;
  logic [15:0] chunk;
  efh_pkg::dw_t y;

  assign y = alu_res_i.y;
  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign result_addr_o = res_q;
  assign status_o = status_q;

  always_comb begin
    chunk = (cfg_q < 16'(efh_pkg::MIN_BLOCK)) ? 16'(efh_pkg::MIN_BLOCK) : cfg_q;
    chunk = chunk & ~16'(efh_pkg::LOW3);
  end

  always_comb begin
    state_d = state_q; ret_d = ret_q; gret_d = gret_q; jret_d = jret_q;
    cfg_d = cfg_we_i ? cfg_wdata_i : cfg_q;
    req_d = req_q; brk_d = brk_q; head_d = head_q; bp_d = bp_q; pv_d = pv_q;
    nd_d = nd_q; nx_d = nx_q; lp_d = lp_q; asz_d = asz_q; sz_d = sz_q;
    rest_d = rest_q; tmp_d = tmp_q; hdr_d = hdr_q; wa_d = wa_q;
    steps_d = steps_q; gfail_d = gfail_q; res_d = res_q; status_d = status_q;
    alu_op_o = '0;
    mem_req_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d = request_bytes_i;
          bp_d = efh_pkg::dw_t'(block_addr_i);
          res_d = '0;
          status_d = efh_pkg::ST_OK;
          case (cmd_i)
            efh_pkg::CMD_ALLOC: state_d = S_A0;
            efh_pkg::CMD_FREE:  state_d = S_F0;
            efh_pkg::CMD_INIT:  state_d = S_I0;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_DONE: state_d = S_IDLE;
      S_I0: begin
        asz_d = efh_pkg::dw_t'(chunk);
        head_d = '0;
        brk_d = 16'd16;
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx('0);
        mem_req_o.wdata = efh_pkg::START_MARK;
        state_d = S_I1;
      end
      S_I1: begin
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(efh_pkg::WSIZE);
        mem_req_o.wdata = efh_pkg::END_MARK;
        gret_d = S_I2;
        state_d = S_G0;
      end
      S_I2: begin
        if (gfail_q) begin
          status_d = efh_pkg::ST_NOSPACE;
          state_d = S_DONE;
        end else begin
          nd_d = bp_q;
          ret_d = S_DONE;
          state_d = S_U0;
        end
      end
      S_G0: begin
        alu_op_o.a = efh_pkg::dw_t'(brk_q);
        alu_op_o.b = asz_q;
        if (y > efh_pkg::HEAP_LIMIT) begin
          gfail_d = 1'b1;
          state_d = gret_q;
        end else begin
          gfail_d = 1'b0;
          tmp_d = y;
          bp_d = efh_pkg::dw_t'(brk_q);
          state_d = S_G1;
        end
      end
      S_G1: begin
        alu_op_o.a = efh_pkg::dw_t'(brk_q);
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        wa_d = y;
        state_d = S_G2;
      end
      S_G2: begin
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(wa_q);
        mem_req_o.wdata = asz_q | (rdata_i & efh_pkg::dw_t'(2));
        state_d = S_G3;
      end
      S_G3: begin
        alu_op_o.a = tmp_q;
        alu_op_o.b = efh_pkg::dw_t'(16);
        alu_op_o.sub = 1'b1;
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(y);
        mem_req_o.wdata = asz_q;
        state_d = S_G4;
      end
      S_G4: begin
        alu_op_o.a = tmp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(y);
        mem_req_o.wdata = efh_pkg::dw_t'(1);
        brk_d = tmp_q[15:0];
        state_d = gret_q;
      end
      S_U0: begin
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(nd_q);
        mem_req_o.wdata = '0;
        state_d = S_U1;
      end
      S_U1: begin
        alu_op_o.a = nd_q;
        alu_op_o.b = efh_pkg::WSIZE;
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(y);
        mem_req_o.wdata = head_q;
        state_d = S_U2;
      end
      S_U2: begin
        if (head_q != '0) begin
          mem_req_o.we = 1'b1;
          mem_req_o.widx = efh_pkg::word_idx(head_q);
          mem_req_o.wdata = nd_q;
        end
        head_d = nd_q;
        state_d = ret_q;
      end
      S_N0: begin
        alu_op_o.a = pv_q;
        alu_op_o.b = efh_pkg::WSIZE;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        wa_d = y;
        state_d = S_N1;
      end
      S_N1: begin
        nx_d = rdata_i;
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(nd_q);
        mem_req_o.wdata = pv_q;
        state_d = S_N2;
      end
      S_N2: begin
        alu_op_o.a = nd_q;
        alu_op_o.b = efh_pkg::WSIZE;
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(y);
        mem_req_o.wdata = nx_q;
        state_d = S_N3;
      end
      S_N3: begin
        if (nx_q != '0) begin
          mem_req_o.we = 1'b1;
          mem_req_o.widx = efh_pkg::word_idx(nx_q);
          mem_req_o.wdata = nd_q;
        end
        state_d = S_N4;
      end
      S_N4: begin
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(wa_q);
        mem_req_o.wdata = nd_q;
        state_d = ret_q;
      end
      S_R0: begin
        mem_req_o.ridx = efh_pkg::word_idx(nd_q);
        state_d = S_R1;
      end
      S_R1: begin
        lp_d = rdata_i;
        alu_op_o.a = nd_q;
        alu_op_o.b = efh_pkg::WSIZE;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        state_d = S_R2;
      end
      S_R2: begin
        nx_d = rdata_i;
        state_d = S_R3;
      end
      S_R3: begin
        alu_op_o.a = lp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        if (lp_q != '0) begin
          mem_req_o.we = 1'b1;
          mem_req_o.widx = efh_pkg::word_idx(y);
          mem_req_o.wdata = nx_q;
        end
        state_d = S_R4;
      end
      S_R4: begin
        if (nx_q != '0) begin
          mem_req_o.we = 1'b1;
          mem_req_o.widx = efh_pkg::word_idx(nx_q);
          mem_req_o.wdata = lp_q;
        end
        if (nd_q == head_q) begin
          head_d = nx_q;
        end
        state_d = ret_q;
      end
      S_A0: begin
        alu_op_o.a = efh_pkg::dw_t'(req_q);
        alu_op_o.b = efh_pkg::LOW3;
        tmp_d = y;
        if (req_q == '0) begin
          status_d = efh_pkg::ST_ZERO;
          state_d = S_DONE;
        end else if (brk_q == '0) begin
          status_d = efh_pkg::ST_NOSPACE;
          state_d = S_DONE;
        end else begin
          state_d = S_A1;
        end
      end
      S_A1: begin
        alu_op_o.a = tmp_q & ~efh_pkg::LOW3;
        alu_op_o.b = efh_pkg::WSIZE;
        asz_d = (y < efh_pkg::MIN_BLOCK) ? efh_pkg::MIN_BLOCK : y;
        bp_d = head_q;
        pv_d = '0;
        steps_d = '0;
        state_d = S_W0;
      end
      S_W0: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        if (bp_q == '0 || steps_q == efh_pkg::STEP_W'(efh_pkg::HEAP_WORDS)) begin
          gret_d = S_AG;
          state_d = S_G0;
        end else begin
          state_d = S_W1;
        end
      end
      S_W1: begin
        alu_op_o.a = rdata_i & ~efh_pkg::LOW2;
        alu_op_o.b = asz_q;
        alu_op_o.sub = 1'b1;
        state_d = alu_res_i.ge ? S_P0 : S_W2;
      end
      S_W2: begin
        pv_d = bp_q;
        alu_op_o.a = bp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        state_d = S_W3;
      end
      S_W3: begin
        bp_d = rdata_i;
        steps_d = steps_q + 1'b1;
        state_d = S_W0;
      end
      S_AG: begin
        if (gfail_q) begin
          status_d = efh_pkg::ST_NOSPACE;
          state_d = S_DONE;
        end else begin
          nd_d = bp_q;
          ret_d = S_P0;
          state_d = (pv_q != '0) ? S_N0 : S_U0;
        end
      end
      S_P0: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        wa_d = y;
        state_d = S_P1;
      end
      S_P1: begin
        hdr_d = rdata_i;
        alu_op_o.a = rdata_i & ~efh_pkg::LOW2;
        alu_op_o.b = asz_q;
        alu_op_o.sub = 1'b1;
        rest_d = y;
        state_d = S_P2;
      end
      S_P2: begin
        if (rest_q >= efh_pkg::MIN_BLOCK) begin
          mem_req_o.we = 1'b1;
          mem_req_o.widx = efh_pkg::word_idx(wa_q);
          mem_req_o.wdata = (hdr_q & efh_pkg::LOW2) | asz_q;
          state_d = S_P3;
        end else begin
          state_d = S_PR;
        end
      end
      S_P3: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = asz_q;
        nd_d = y;
        state_d = S_P4;
      end
      S_P4: begin
        alu_op_o.a = nd_q;
        alu_op_o.b = efh_pkg::dw_t'(16);
        alu_op_o.sub = 1'b1;
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(y);
        mem_req_o.wdata = asz_q;
        state_d = S_P5;
      end
      S_P5: begin
        alu_op_o.a = nd_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(y);
        mem_req_o.wdata = rest_q;
        state_d = S_P6;
      end
      S_P6: begin
        alu_op_o.a = nd_q;
        alu_op_o.b = rest_q;
        tmp_d = y;
        state_d = S_P7;
      end
      S_P7: begin
        alu_op_o.a = tmp_q;
        alu_op_o.b = efh_pkg::dw_t'(16);
        alu_op_o.sub = 1'b1;
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(y);
        mem_req_o.wdata = rest_q;
        pv_d = bp_q;
        ret_d = S_PR;
        state_d = S_N0;
      end
      S_PR: begin
        nd_d = bp_q;
        ret_d = S_P8;
        state_d = S_R0;
      end
      S_P8: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        wa_d = y;
        state_d = S_P9;
      end
      S_P9: begin
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(wa_q);
        mem_req_o.wdata = rdata_i | efh_pkg::dw_t'(1);
        sz_d = rdata_i & ~efh_pkg::LOW2;
        state_d = S_P10;
      end
      S_P10: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = sz_q;
        tmp_d = y;
        state_d = S_P11;
      end
      S_P11: begin
        alu_op_o.a = tmp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        wa_d = y;
        state_d = S_P12;
      end
      S_P12: begin
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(wa_q);
        mem_req_o.wdata = rdata_i | efh_pkg::dw_t'(2);
        res_d = bp_q[14:0];
        status_d = efh_pkg::ST_OK;
        state_d = S_DONE;
      end
      S_F0: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = efh_pkg::dw_t'(brk_q);
        alu_op_o.sub = 1'b1;
        if (brk_q == '0 || bp_q < efh_pkg::dw_t'(16) || alu_res_i.ge ||
            bp_q[2:0] != 3'd0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_F1;
        end
      end
      S_F1: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        wa_d = y;
        state_d = S_F2;
      end
      S_F2: begin
        if (!rdata_i[0]) begin
          state_d = S_DONE;
        end else begin
          mem_req_o.we = 1'b1;
          mem_req_o.widx = efh_pkg::word_idx(wa_q);
          mem_req_o.wdata = rdata_i & ~efh_pkg::dw_t'(1);
          sz_d = rdata_i & ~efh_pkg::LOW2;
          state_d = S_F3;
        end
      end
      S_F3: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = sz_q;
        tmp_d = y;
        state_d = S_F4;
      end
      S_F4: begin
        alu_op_o.a = tmp_q;
        alu_op_o.b = efh_pkg::dw_t'(16);
        alu_op_o.sub = 1'b1;
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(y);
        mem_req_o.wdata = sz_q;
        state_d = S_F5;
      end
      S_F5: begin
        alu_op_o.a = tmp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        wa_d = y;
        state_d = S_F6;
      end
      S_F6: begin
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(wa_q);
        mem_req_o.wdata = rdata_i & ~efh_pkg::dw_t'(2);
        nd_d = bp_q;
        ret_d = S_F7;
        state_d = S_U0;
      end
      S_F7: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        state_d = S_F8;
      end
      S_F8: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = efh_pkg::dw_t'(16);
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        state_d = rdata_i[1] ? S_F11 : S_F9;
      end
      S_F9: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = rdata_i & ~efh_pkg::LOW2;
        alu_op_o.sub = 1'b1;
        nd_d = bp_q;
        bp_d = y;
        jret_d = S_F11;
        state_d = S_J0;
      end
      S_F11: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        state_d = S_F12;
      end
      S_F12: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = rdata_i & ~efh_pkg::LOW2;
        tmp_d = y;
        state_d = S_F13;
      end
      S_F13: begin
        alu_op_o.a = tmp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        state_d = S_F14;
      end
      S_F14: begin
        if (!rdata_i[0]) begin
          nd_d = tmp_q;
          jret_d = S_DONE;
          state_d = S_J0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_J0: begin
        ret_d = S_J1;
        state_d = S_R0;
      end
      S_J1: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        wa_d = y;
        state_d = S_J2;
      end
      S_J2: begin
        hdr_d = rdata_i;
        sz_d = rdata_i & ~efh_pkg::LOW2;
        alu_op_o.a = nd_q;
        alu_op_o.b = efh_pkg::WSIZE;
        alu_op_o.sub = 1'b1;
        mem_req_o.ridx = efh_pkg::word_idx(y);
        state_d = S_J3;
      end
      S_J3: begin
        alu_op_o.a = sz_q;
        alu_op_o.b = rdata_i & ~efh_pkg::LOW2;
        sz_d = y;
        state_d = S_J4;
      end
      S_J4: begin
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(wa_q);
        mem_req_o.wdata = (hdr_q & efh_pkg::LOW2) | sz_q;
        state_d = S_J5;
      end
      S_J5: begin
        alu_op_o.a = bp_q;
        alu_op_o.b = sz_q & ~efh_pkg::LOW2;
        tmp_d = y;
        state_d = S_J6;
      end
      S_J6: begin
        alu_op_o.a = tmp_q;
        alu_op_o.b = efh_pkg::dw_t'(16);
        alu_op_o.sub = 1'b1;
        mem_req_o.we = 1'b1;
        mem_req_o.widx = efh_pkg::word_idx(y);
        mem_req_o.wdata = sz_q;
        state_d = jret_q;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      gret_q <= S_IDLE;
      jret_q <= S_IDLE;
      cfg_q <= efh_pkg::CHUNK_RESET;
      brk_q <= '0;
      head_q <= '0;
      res_q <= '0;
      status_q <= efh_pkg::ST_OK;
      gfail_q <= 1'b0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      gret_q <= gret_d;
      jret_q <= jret_d;
      cfg_q <= cfg_d;
      brk_q <= brk_d;
      head_q <= head_d;
      res_q <= res_d;
      status_q <= status_d;
      gfail_q <= gfail_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    bp_q <= bp_d;
    pv_q <= pv_d;
    nd_q <= nd_d;
    nx_q <= nx_d;
    lp_q <= lp_d;
    asz_q <= asz_d;
    sz_q <= sz_d;
    rest_q <= rest_d;
    tmp_q <= tmp_d;
    hdr_q <= hdr_d;
    wa_q <= wa_d;
  end

endmodule

### rtl/explicit_free_list_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// explicit_free_list_heap_allocator
// Init ends early when the chunk does not fit, and allocate takes longer for
// each free-list entry walked. One memory access per cycle sets the pace.
// One request at a time: start is taken only while busy is low, so the next
// request can be taken in the cycle after done.
// The result shows for one cycle with done; the receiver cannot stall.
// Reset empties the free list, clears the break and sets the chunk to 1024.
// ----------------------------------------------------------------------------
module explicit_free_list_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        done_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] request_bytes_i,
  input  logic [14:0] block_addr_i,
  output logic [14:0] result_addr_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  efh_pkg::alu_op_t  alu_op;
  efh_pkg::alu_res_t alu_res;
  efh_pkg::mem_req_t mem_req;
  efh_pkg::dw_t      rdata;

  efh_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .cmd_i           (cmd_i),
    .request_bytes_i (request_bytes_i),
    .block_addr_i    (block_addr_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .result_addr_o   (result_addr_o),
    .status_o        (status_o),
    .alu_op_o        (alu_op),
    .alu_res_i       (alu_res),
    .mem_req_o       (mem_req),
    .rdata_i         (rdata)
  );

  efh_alu u_alu (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  efh_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

endmodule

### tb/explicit_free_list_heap_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// explicit_free_list_heap_allocator_tb
// Drives allocate, free, init and nop requests into the heap allocator and checks
// every result against a cycle-free model of the heap kept in the bench.
// ----------------------------------------------------------------------------
module explicit_free_list_heap_allocator_tb;

  typedef bit [63:0] u64_t;

  typedef struct {
    logic [14:0] addr;
    logic [1:0]  status;
  } heap_result_t;

  localparam int unsigned CYCLE_LIMIT = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  cmd_i = efh_pkg::CMD_ALLOC;
  logic [15:0] request_bytes_i = '0;
  logic [14:0] block_addr_i = '0;
  logic [14:0] result_addr_o;
  logic [1:0]  status_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  u64_t         heap_mem [efh_pkg::HEAP_WORDS];
  u64_t         free_head;
  u64_t         heap_brk;
  logic [15:0]  chunk_reg;
  u64_t         live_blocks [$];
  heap_result_t pending_results [$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  idle_pct = 0;

  explicit_free_list_heap_allocator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .cmd_i           (cmd_i),
    .request_bytes_i (request_bytes_i),
    .block_addr_i    (block_addr_i),
    .result_addr_o   (result_addr_o),
    .status_o        (status_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic u64_t hrd(u64_t a);
    return heap_mem[a[14:3]];
  endfunction

  function automatic void hwr(u64_t a, u64_t v);
    heap_mem[a[14:3]] = v;
  endfunction

  function automatic u64_t blk_size(u64_t bp);
    return hrd(bp - 8) & ~u64_t'(3);
  endfunction

  function automatic void set_blk_size(u64_t bp, u64_t sz);
    hwr(bp - 8, (hrd(bp - 8) & u64_t'(3)) | sz);
    hwr(bp + blk_size(bp) - 16, sz);
  endfunction

  function automatic void unlink(u64_t bp);
    u64_t p;
    u64_t n;
    p = hrd(bp);
    n = hrd(bp + 8);
    if (p != 0) hwr(p + 8, n);
    if (n != 0) hwr(n, p);
    if (bp == free_head) free_head = n;
  endfunction

  function automatic void link_after(u64_t bp, u64_t prev);
    u64_t n;
    n = hrd(prev + 8);
    hwr(bp, prev);
    hwr(bp + 8, n);
    if (n != 0) hwr(n, bp);
    hwr(prev + 8, bp);
  endfunction

  function automatic void push_head(u64_t bp);
    hwr(bp, 0);
    hwr(bp + 8, free_head);
    if (free_head != 0) hwr(free_head, bp);
    free_head = bp;
  endfunction

  function automatic u64_t merge(u64_t a, u64_t b);
    unlink(b);
    set_blk_size(a, blk_size(a) + blk_size(b));
    return a;
  endfunction

  function automatic u64_t grow_heap(u64_t sz);
    u64_t bp;
    bp = heap_brk;
    if (bp + sz > efh_pkg::HEAP_BYTES) return 0;
    hwr(bp - 8, sz | (hrd(bp - 8) & u64_t'(2)));
    hwr(bp + sz - 16, sz);
    hwr(bp + sz - 8, 1);
    heap_brk = bp + sz;
    return bp;
  endfunction

  function automatic u64_t carve(u64_t bp, u64_t asize);
    u64_t sz;
    u64_t rest;
    sz = blk_size(bp);
    if (sz - asize >= 32) begin
      rest = sz - asize;
      set_blk_size(bp, asize);
      hwr(bp + asize - 8, rest);
      hwr(bp + asize + rest - 16, rest);
      link_after(bp + asize, bp);
    end
    unlink(bp);
    hwr(bp - 8, hrd(bp - 8) | 1);
    hwr(bp + blk_size(bp) - 8, hrd(bp + blk_size(bp) - 8) | 2);
    return bp;
  endfunction

  function automatic logic [1:0] heap_init();
    u64_t chunk;
    u64_t bp;
    chunk = chunk_reg;
    if (chunk < 32) chunk = 32;
    chunk &= ~u64_t'(7);
    free_head = 0;
    heap_brk = 16;
    hwr(0, 8 | 3);
    hwr(8, 3);
    live_blocks.delete();
    bp = grow_heap(chunk);
    if (bp == 0) return efh_pkg::ST_NOSPACE;
    push_head(bp);
    return efh_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] heap_alloc(u64_t req, output u64_t addr);
    u64_t asize;
    u64_t bp;
    u64_t prev;
    int unsigned steps;
    addr = 0;
    prev = 0;
    if (req == 0) return efh_pkg::ST_ZERO;
    if (heap_brk == 0) return efh_pkg::ST_NOSPACE;
    asize = ((req + 7) & ~u64_t'(7)) + 8;
    if (asize < 32) asize = 32;
    bp = free_head;
    steps = 0;
    while (bp != 0 && steps < efh_pkg::HEAP_WORDS) begin
      if (blk_size(bp) >= asize) begin
        addr = carve(bp, asize);
        return efh_pkg::ST_OK;
      end
      prev = bp;
      bp = hrd(bp + 8);
      steps++;
    end
    bp = grow_heap(asize);
    if (bp == 0) return efh_pkg::ST_NOSPACE;
    if (prev != 0) link_after(bp, prev);
    else push_head(bp);
    addr = carve(bp, asize);
    return efh_pkg::ST_OK;
  endfunction

  function automatic void heap_free(u64_t bp);
    u64_t w;
    if (heap_brk == 0 || bp < 16 || bp >= heap_brk || bp[2:0] != 0) return;
    w = hrd(bp - 8);
    if (w[0] == 1'b0) return;
    foreach (live_blocks[i]) if (live_blocks[i] == bp) begin
      live_blocks.delete(i);
      break;
    end
    hwr(bp - 8, hrd(bp - 8) & ~u64_t'(1));
    hwr(bp + blk_size(bp) - 16, blk_size(bp));
    hwr(bp + blk_size(bp) - 8, hrd(bp + blk_size(bp) - 8) & ~u64_t'(2));
    push_head(bp);
    w = hrd(bp - 8);
    if (w[1] == 1'b0) bp = merge(bp - (hrd(bp - 16) & ~u64_t'(3)), bp);
    w = hrd(bp + blk_size(bp) - 8);
    if (w[0] == 1'b0) bp = merge(bp, bp + blk_size(bp));
  endfunction

  function automatic heap_result_t predict_heap(logic [1:0] cmd, logic [15:0] req,
                                                logic [14:0] baddr);
    heap_result_t r;
    u64_t a;
    r.addr = '0;
    r.status = efh_pkg::ST_OK;
    if (cmd == efh_pkg::CMD_ALLOC) begin
      r.status = heap_alloc(req, a);
      r.addr = a[14:0];
      if (r.status == efh_pkg::ST_OK) live_blocks.push_back(a);
    end else if (cmd == efh_pkg::CMD_FREE) begin
      heap_free(baddr);
    end else if (cmd == efh_pkg::CMD_INIT) begin
      r.status = heap_init();
    end
    return r;
  endfunction

  task automatic send_req(logic [1:0] cmd, logic [15:0] req, logic [14:0] baddr);
    bit taken;
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    cmd_i = cmd;
    request_bytes_i = req;
    block_addr_i = baddr;
    start_i = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
    end
    pending_results.push_back(predict_heap(cmd, req, baddr));
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_chunk(logic [15:0] value);
    drain();
    cfg_wdata_i = value;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    chunk_reg = value;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result addr=%0d status=%0d",
                                       result_addr_o, status_o);
      end else begin
        if (result_addr_o !== pending_results[0].addr ||
            status_o !== pending_results[0].status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                     pending_results[0].addr, pending_results[0].status,
                     result_addr_o, status_o);
        end
        void'(pending_results.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_before_init();
    send_req(efh_pkg::CMD_ALLOC, 16'd40, '0);
    send_req(efh_pkg::CMD_ALLOC, 16'd0, '0);
    send_req(efh_pkg::CMD_FREE, '0, 15'd16);
    send_req(efh_pkg::CMD_NOP, 16'hffff, 15'h7fff);
  endtask

  task automatic test_alloc_free_edges();
    u64_t b [4];
    send_req(efh_pkg::CMD_INIT, '0, '0);
    for (int i = 0; i < 4; i++) begin
      send_req(efh_pkg::CMD_ALLOC, 16'(1 + i * 24), '0);
      b[i] = live_blocks[$];
    end
    send_req(efh_pkg::CMD_ALLOC, 16'd32768, '0);
    send_req(efh_pkg::CMD_ALLOC, 16'hffff, '0);
    send_req(efh_pkg::CMD_ALLOC, 16'd0, '0);
    send_req(efh_pkg::CMD_FREE, '0, b[1][14:0]);
    send_req(efh_pkg::CMD_FREE, '0, b[1][14:0]);
    send_req(efh_pkg::CMD_FREE, '0, b[2][14:0]);
    send_req(efh_pkg::CMD_FREE, '0, b[0][14:0]);
    send_req(efh_pkg::CMD_FREE, '0, 15'd0);
    send_req(efh_pkg::CMD_FREE, '0, b[3][14:0] | 15'd4);
    send_req(efh_pkg::CMD_FREE, '0, 15'h7fff);
    send_req(efh_pkg::CMD_ALLOC, 16'd24, '0);
    send_req(efh_pkg::CMD_ALLOC, 16'd25, '0);
    send_req(efh_pkg::CMD_ALLOC, 16'd4000, '0);
  endtask

  task automatic test_chunk_settings();
    logic [15:0] vals [7] = '{16'd0, 16'd8, 16'd1001, 16'd32752, 16'd32768,
                              16'hffff, 16'd1024};
    foreach (vals[i]) begin
      write_chunk(vals[i]);
      send_req(efh_pkg::CMD_INIT, '0, '0);
      send_req(efh_pkg::CMD_ALLOC, 16'd16, '0);
      send_req(efh_pkg::CMD_ALLOC, 16'd100, '0);
      if (live_blocks.size() != 0)
        send_req(efh_pkg::CMD_FREE, '0, live_blocks[0][14:0]);
    end
  endtask

  task automatic test_random(int unsigned n, int unsigned pct);
    int unsigned pick;
    int unsigned k;
    logic [14:0] a;
    idle_pct = pct;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (heap_brk == 0 || pick < 1) begin
        send_req(efh_pkg::CMD_INIT, 16'($urandom), 15'($urandom));
      end else if (pick < 48) begin
        if ($urandom_range(19) == 0)
          send_req(efh_pkg::CMD_ALLOC, 16'($urandom), 15'($urandom));
        else if ($urandom_range(9) == 0)
          send_req(efh_pkg::CMD_ALLOC, 16'($urandom_range(4096)), 15'($urandom));
        else send_req(efh_pkg::CMD_ALLOC, 16'($urandom_range(1, 256)), 15'($urandom));
      end else if (pick < 90 && live_blocks.size() != 0) begin
        k = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[k][14:0];
        send_req(efh_pkg::CMD_FREE, 16'($urandom), a);
        if ($urandom_range(9) == 0) send_req(efh_pkg::CMD_FREE, 16'($urandom), a);
      end else if (pick < 97) begin
        a = 15'($urandom);
        if (a >= 16 && a < heap_brk && a[2:0] == 0) a[0] = 1'b1;
        send_req(efh_pkg::CMD_FREE, 16'($urandom), a);
      end else begin
        send_req(efh_pkg::CMD_NOP, 16'($urandom), 15'($urandom));
      end
    end
  endtask

  initial begin
    foreach (heap_mem[i]) heap_mem[i] = '0;
    free_head = 0;
    heap_brk = 0;
    chunk_reg = efh_pkg::CHUNK_RESET;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_before_init();
    test_alloc_free_edges();
    test_chunk_settings();
    write_chunk(16'd1024);
    test_random(450, 17);
    drain();
    write_chunk(16'd4096);
    test_random(450, 55);
    drain();
    write_chunk(16'd256);
    test_random(450, 0);
    drain();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/efh_pkg.sv
rtl/efh_alu.sv
rtl/efh_ram.sv
rtl/efh_ctrl.sv
rtl/explicit_free_list_heap_allocator.sv
tb/explicit_free_list_heap_allocator_tb.sv
